>>> rtl/sorted_timer_queue_assert.svh
// assertion macros used by the checker
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_timer_queue check failed");

// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_timer_queue check failed");

`endif

>>> rtl/stq_pkg.sv
`timescale 1ns / 1ps
package stq_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_ADJUST = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_TICK   = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EXPIRED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // most expirations handed out by one tick
    localparam int MAX_RESULTS = 16;
    localparam int TICK_W      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [31:0] expiry;
        logic [7:0]  handle;
    } entry_t;

endpackage

>>> rtl/sorted_timer_queue.sv
`timescale 1ns / 1ps
// channel   | signals                                        | handshake
// command   | action, handle, expire_time, now_time          | start && !busy
// result    | status, out_handle, last                       | result_valid, one cycle
//
// entries sit in a circular table memory in expiry order, one read and one write a cycle.
// add/adjust/delete walk the table entry by entry, comparing or shifting, then end the walk and write.
// tick: walks expired entries (at most 16) from the head; head pointer moves, no shifting.
// rst_n clears count, head and control; table contents need no clearing.
// results cannot be stalled; busy holds off commands until the last beat.
module sorted_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  handle,
    input  logic [31:0] expire_time,
    input  logic [31:0] now_time,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [7:0]  out_handle,
    output logic        last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 1;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_FRD  = 13'b0000000000010,
        S_FCHK = 13'b0000000000100,
        S_RRD  = 13'b0000000001000,
        S_RWR  = 13'b0000000010000,
        S_PRD  = 13'b0000000100000,
        S_PCHK = 13'b0000001000000,
        S_URD  = 13'b0000010000000,
        S_UWR  = 13'b0000100000000,
        S_INS  = 13'b0001000000000,
        S_TRD  = 13'b0010000000000,
        S_TCHK = 13'b0100000000000,
        S_SPR  = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             act_reg, act_next;
    logic [7:0]             hnd_reg, hnd_next;
    logic [31:0]            exp_reg, exp_next;
    logic [31:0]            now_reg, now_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [stq_pkg::TICK_W-1:0] ntick_reg, ntick_next;
    logic                   pend_reg, pend_next;
    logic [7:0]             pend_h_reg, pend_h_next;
    logic                   rv_reg, rv_next;
    logic [2:0]             st_reg, st_next;
    logic [7:0]             oh_reg, oh_next;
    logic                   last_reg, last_next;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr, rd_addr;
    stq_pkg::entry_t        wr_data, rd_data;

    // logical position to table address
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] i);
        logic [PW-1:0] s;
        s = PW'(h) + PW'(i);
        if (s >= PW'(DEPTH))
        begin
            s = s - PW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    stq_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        hnd_next    = hnd_reg;
        exp_next    = exp_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        ntick_next  = ntick_reg;
        pend_next   = pend_reg;
        pend_h_next = pend_h_reg;
        rv_next     = 1'b0;
        st_next     = st_reg;
        oh_next     = oh_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        wr_addr     = phys(head_reg, idx_reg);
        wr_data     = rd_data;
        rd_addr     = phys(head_reg, idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    hnd_next   = handle;
                    exp_next   = expire_time;
                    now_next   = now_time;
                    idx_next   = '0;
                    ntick_next = '0;
                    pend_next  = 1'b0;
                    state_next = (action == stq_pkg::ACT_TICK) ? S_TRD : S_FRD;
                end
            end
            S_FRD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (act_reg == stq_pkg::ACT_ADD)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            rv_next = 1'b1; st_next = stq_pkg::ST_FULL;
                            oh_next = hnd_reg; last_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_PRD;
                        end
                    end
                    else
                    begin
                        rv_next = 1'b1; st_next = stq_pkg::ST_NOT_FOUND;
                        oh_next = hnd_reg; last_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (rd_data.handle == hnd_reg)
                begin
                    if (act_reg == stq_pkg::ACT_ADD)
                    begin
                        rv_next = 1'b1; st_next = stq_pkg::ST_DUPLICATE;
                        oh_next = hnd_reg; last_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RRD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_RRD:
            begin
                // close the gap left by the removed entry
                if ((PW'(idx_reg) + PW'(1)) >= PW'(cnt_reg))
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (act_reg == stq_pkg::ACT_ADJUST)
                    begin
                        idx_next   = '0;
                        state_next = S_PRD;
                    end
                    else
                    begin
                        rv_next = 1'b1; st_next = stq_pkg::ST_DONE;
                        oh_next = hnd_reg; last_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_addr    = phys(head_reg, idx_reg + 1'b1);
                    state_next = S_RWR;
                end
            end
            S_RWR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_RRD;
            end
            S_PRD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (rd_data.expiry <= exp_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PRD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    rd_addr    = phys(head_reg, idx_reg - 1'b1);
                    state_next = S_UWR;
                end
            end
            S_UWR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - 1'b1;
                state_next = S_URD;
            end
            S_INS:
            begin
                wr_en       = 1'b1;
                wr_addr     = phys(head_reg, pos_reg);
                wr_data     = '{expiry: exp_reg, handle: hnd_reg};
                cnt_next    = cnt_reg + 1'b1;
                rv_next = 1'b1; st_next = stq_pkg::ST_DONE;
                oh_next = hnd_reg; last_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_TRD:
            begin
                if (cnt_reg == '0 || ntick_reg == stq_pkg::TICK_W'(stq_pkg::MAX_RESULTS))
                begin
                    state_next = S_SPR;
                end
                else
                begin
                    rd_addr    = head_reg;
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (rd_data.expiry <= now_reg)
                begin
                    // previous expiry goes out now that another one follows
                    if (pend_reg)
                    begin
                        rv_next = 1'b1; st_next = stq_pkg::ST_EXPIRED;
                        oh_next = pend_h_reg; last_next = 1'b0;
                    end
                    pend_next   = 1'b1;
                    pend_h_next = rd_data.handle;
                    head_next   = phys(head_reg, CW'(1));
                    cnt_next    = cnt_reg - 1'b1;
                    ntick_next  = ntick_reg + 1'b1;
                    state_next  = S_TRD;
                end
                else
                begin
                    state_next = S_SPR;
                end
            end
            S_SPR:
            begin
                rv_next   = 1'b1;
                last_next = 1'b1;
                if (pend_reg)
                begin
                    st_next = stq_pkg::ST_EXPIRED;
                    oh_next = pend_h_reg;
                end
                else
                begin
                    st_next = stq_pkg::ST_NONE;
                    oh_next = '0;
                end
                pend_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
            ntick_reg <= '0;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            ntick_reg <= ntick_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        hnd_reg    <= hnd_next;
        exp_reg    <= exp_next;
        now_reg    <= now_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        pend_h_reg <= pend_h_next;
        st_reg     <= st_next;
        oh_reg     <= oh_next;
        last_reg   <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign out_handle   = oh_reg;
    assign last         = last_reg;

endmodule

>>> rtl/stq_mem.sv
`timescale 1ns / 1ps
module stq_mem #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  stq_pkg::entry_t           wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output stq_pkg::entry_t           rd_data
);

    stq_pkg::entry_t mem [DEPTH];
    stq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/stq_checker.sv
`timescale 1ns / 1ps
`include "sorted_timer_queue_assert.svh"
module stq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [2:0] status,
    input logic [7:0] out_handle,
    input logic       last
);

    // every accepted command raises busy in the cycle after start
    `STQ_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // the final beat frees the block, earlier beats keep it busy
    `STQ_ASSERT_NOW(a_last_busy, result_valid, busy == !last)
    // only expirations come in bursts
    `STQ_ASSERT_NOW(a_single_last, result_valid && status != stq_pkg::ST_EXPIRED, last)
    `STQ_ASSERT_NOW(a_none_zero, result_valid && status == stq_pkg::ST_NONE, out_handle == 8'd0)

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .out_handle   (out_handle),
    .last         (last)
);
